/* src/bba_pkg.sv */
// Shared types, constants and codes of the bitmap block allocator.
package bba_pkg;

    localparam int WORDS      = 32;
    localparam int WORD_BITS  = 32;
    localparam int WORD_IDX_W = $clog2(WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int INDEX_W    = WORD_IDX_W + BIT_IDX_W;
    localparam int WC_W       = 6;
    localparam int BS_W       = 17;
    localparam int ADDR_W     = 32;
    localparam int OFF_W      = INDEX_W + BS_W - 1;
    localparam int PROD_W     = INDEX_W + BS_W;
    localparam int DIV_CNT_W  = $clog2(INDEX_W + 1);

    localparam logic [BS_W-1:0] MAX_BLOCK = BS_W'(65536);

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_ADDR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_WORD_COUNT = 2'd0,
        CFG_BLOCK_SIZE = 2'd1,
        CFG_HEAP_BASE  = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK,
        S_MUL,
        S_ADDR,
        S_TOT,
        S_RANGE,
        S_DIV,
        S_RRD,
        S_RWR,
        S_DONE
    } state_t;

    // Request bundle from the sequencer to the bitmap store.
    typedef struct packed {
        logic                  rd_en;
        logic [WORD_IDX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [WORD_IDX_W-1:0] wr_addr;
        logic [WORD_BITS-1:0]  wr_data;
        logic                  clear;
    } bm_ctrl_t;

endpackage

/* src/bitmap_block_allocator_core.sv */
// Top level of the bitmap block allocator: sequencer, configuration and result register.
//
// The block hands out and takes back fixed-size heap blocks tracked in a bitmap.
// Request beats arrive on the s_ stream (action, request size, release address)
// and each one produces exactly one result beat on the m_ stream (status, block
// index, block address). Configuration (word count, block size, heap base) is
// written through the cfg_ port; the user must write it only while the block is
// idle, as the block does not enforce it. One request is worked on at a time;
// s_tready is high only while the sequencer is idle. An allocate wraps the
// search hint inside the word count, then reads and checks one bitmap word at a
// time until one has room. A release inside the heap runs the ten-step restoring
// divider, then reads and rewrites the bitmap word; one outside the heap stops
// at the range check. A clear, a bad size or the unused action goes straight to
// the result. The next request beat can be taken in the same cycle as the result
// shows up. The result sits in an output register, so a stalled receiver only
// holds the sequencer once a second result is ready behind it.
// Reset empties the bitmap at once through per-word valid bits, zeroes the search
// hint and loads the configuration defaults: 32 words, 64-byte blocks, base 0.
module bitmap_block_allocator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action [1:0], request_size [18:2], release_address [50:19], zero fill above
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status [1:0], block_index [11:2], block_address [43:12], zero fill above
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int WI = bba_pkg::WORD_IDX_W;
    localparam int BI = bba_pkg::BIT_IDX_W;
    localparam int IW = bba_pkg::INDEX_W;
    localparam int WC = bba_pkg::WC_W;
    localparam int BS = bba_pkg::BS_W;
    localparam int AW = bba_pkg::ADDR_W;
    localparam int PW = bba_pkg::PROD_W;

    // Configuration registers.
    logic [WC-1:0] word_count_reg;
    logic [BS-1:0] block_size_reg;
    logic [AW-1:0] heap_base_reg;

    // Sequencer and datapath registers.
    bba_pkg::state_t  state_reg,      state_next;
    logic [WI-1:0]    hint_reg,       hint_next;
    logic [WI-1:0]    word_ptr_reg,   word_ptr_next;
    logic [WC-1:0]    scan_cnt_reg,   scan_cnt_next;
    logic [IW-1:0]    idx_reg,        idx_next;
    logic [PW-1:0]    prod_reg,       prod_next;
    logic [AW-1:0]    req_addr_reg,   req_addr_next;
    logic [AW-1:0]    off_reg,        off_next;
    bba_pkg::status_t res_status_reg, res_status_next;
    logic [AW-1:0]    res_addr_reg,   res_addr_next;

    // Output register.
    logic             out_valid_reg,  out_valid_next;
    bba_pkg::status_t out_status_reg, out_status_next;
    logic [IW-1:0]    out_index_reg,  out_index_next;
    logic [AW-1:0]    out_addr_reg,   out_addr_next;

    // Request fields.
    bba_pkg::action_t in_action;
    logic [BS-1:0]    in_size;
    logic [AW-1:0]    in_addr;

    // Effective configuration.
    logic [WC-1:0] wc_eff;
    logic [BS-1:0] bs_eff;

    // Bitmap and divider connections.
    bba_pkg::bm_ctrl_t              bm_ctrl;
    logic [bba_pkg::WORD_BITS-1:0]  rd_word;
    logic [BI-1:0]                  free_bit;
    logic                           div_start;
    logic                           div_busy;
    logic [IW-1:0]                  div_quot;
    logic [BS-1:0]                  div_rem;

    logic [WC-1:0] scan_cnt_inc;
    logic [WC-1:0] word_ptr_inc;
    logic          out_free;

    assign in_action = bba_pkg::action_t'(s_tdata[1:0]);
    assign in_size   = s_tdata[18:2];
    assign in_addr   = s_tdata[50:19];

    // Out-of-range settings are clamped rather than rejected.
    always_comb
    begin
        if (word_count_reg == '0)
        begin
            wc_eff = WC'(1);
        end
        else if (word_count_reg > WC'(bba_pkg::WORDS))
        begin
            wc_eff = WC'(bba_pkg::WORDS);
        end
        else
        begin
            wc_eff = word_count_reg;
        end

        if (block_size_reg == '0)
        begin
            bs_eff = BS'(1);
        end
        else if (block_size_reg > bba_pkg::MAX_BLOCK)
        begin
            bs_eff = bba_pkg::MAX_BLOCK;
        end
        else
        begin
            bs_eff = block_size_reg;
        end
    end

    // Lowest clear bit of the word just read; only used when the word is not full.
    always_comb
    begin
        free_bit = '0;
        for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rd_word[i])
            begin
                free_bit = BI'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= WC'(32);
            block_size_reg <= BS'(64);
            heap_base_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (bba_pkg::cfg_index_t'(cfg_index))
                bba_pkg::CFG_WORD_COUNT: word_count_reg <= cfg_data[WC-1:0];
                bba_pkg::CFG_BLOCK_SIZE: block_size_reg <= cfg_data[BS-1:0];
                bba_pkg::CFG_HEAP_BASE:  heap_base_reg  <= cfg_data[AW-1:0];
                default:                 ;
            endcase
        end
    end

    assign s_tready     = (state_reg == bba_pkg::S_IDLE);
    assign out_free     = !out_valid_reg || m_tready;
    assign scan_cnt_inc = scan_cnt_reg + 1'b1;
    assign word_ptr_inc = WC'(word_ptr_reg) + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        hint_next       = hint_reg;
        word_ptr_next   = word_ptr_reg;
        scan_cnt_next   = scan_cnt_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        req_addr_next   = req_addr_reg;
        off_next        = off_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_addr_next   = out_addr_reg;
        bm_ctrl         = '0;
        div_start       = 1'b0;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_status_next = bba_pkg::ST_OK;
                    res_addr_next   = '0;
                    idx_next        = '0;
                    state_next      = bba_pkg::S_DONE;
                    case (in_action)
                        bba_pkg::ACT_ALLOC:
                        begin
                            if (in_size == '0 || in_size > bs_eff)
                            begin
                                res_status_next = bba_pkg::ST_BAD_SIZE;
                            end
                            else
                            begin
                                word_ptr_next = hint_reg;
                                state_next    = bba_pkg::S_MOD;
                            end
                        end
                        bba_pkg::ACT_RELEASE:
                        begin
                            req_addr_next = in_addr;
                            off_next      = in_addr - heap_base_reg;
                            state_next    = bba_pkg::S_TOT;
                        end
                        bba_pkg::ACT_CLEAR:
                        begin
                            bm_ctrl.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Bring the hint below the word count by repeated subtraction.
            bba_pkg::S_MOD:
            begin
                if (WC'(word_ptr_reg) >= wc_eff)
                begin
                    word_ptr_next = WI'(WC'(word_ptr_reg) - wc_eff);
                end
                else
                begin
                    scan_cnt_next = '0;
                    state_next    = bba_pkg::S_RD;
                end
            end

            bba_pkg::S_RD:
            begin
                bm_ctrl.rd_en   = 1'b1;
                bm_ctrl.rd_addr = word_ptr_reg;
                state_next      = bba_pkg::S_CHK;
            end

            bba_pkg::S_CHK:
            begin
                if (&rd_word)
                begin
                    scan_cnt_next = scan_cnt_inc;
                    if (scan_cnt_inc == wc_eff)
                    begin
                        res_status_next = bba_pkg::ST_FULL;
                        state_next      = bba_pkg::S_DONE;
                    end
                    else
                    begin
                        word_ptr_next = (word_ptr_inc == wc_eff) ? '0 : WI'(word_ptr_inc);
                        state_next    = bba_pkg::S_RD;
                    end
                end
                else
                begin
                    bm_ctrl.wr_en   = 1'b1;
                    bm_ctrl.wr_addr = word_ptr_reg;
                    bm_ctrl.wr_data = rd_word
                                    | (bba_pkg::WORD_BITS'(1) << free_bit);
                    hint_next       = word_ptr_reg;
                    idx_next        = {word_ptr_reg, free_bit};
                    state_next      = bba_pkg::S_MUL;
                end
            end

            bba_pkg::S_MUL:
            begin
                prod_next  = PW'(idx_reg) * PW'(bs_eff);
                state_next = bba_pkg::S_ADDR;
            end

            bba_pkg::S_ADDR:
            begin
                res_addr_next = heap_base_reg + AW'(prod_reg);
                state_next    = bba_pkg::S_DONE;
            end

            // Heap size in words-times-bytes, shifted by the word width later.
            bba_pkg::S_TOT:
            begin
                prod_next  = PW'(bs_eff) * PW'(wc_eff);
                state_next = bba_pkg::S_RANGE;
            end

            bba_pkg::S_RANGE:
            begin
                if (off_reg >= AW'({prod_reg, BI'(0)}))
                begin
                    res_status_next = bba_pkg::ST_BAD_ADDR;
                    state_next      = bba_pkg::S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = bba_pkg::S_DIV;
                end
            end

            // The block start is the release address minus the remainder.
            bba_pkg::S_DIV:
            begin
                if (!div_busy)
                begin
                    idx_next      = div_quot;
                    res_addr_next = req_addr_reg - AW'(div_rem);
                    state_next    = bba_pkg::S_RRD;
                end
            end

            bba_pkg::S_RRD:
            begin
                bm_ctrl.rd_en   = 1'b1;
                bm_ctrl.rd_addr = idx_reg[IW-1:BI];
                state_next      = bba_pkg::S_RWR;
            end

            bba_pkg::S_RWR:
            begin
                bm_ctrl.wr_en   = 1'b1;
                bm_ctrl.wr_addr = idx_reg[IW-1:BI];
                bm_ctrl.wr_data = rd_word
                                & ~(bba_pkg::WORD_BITS'(1) << idx_reg[BI-1:0]);
                state_next      = bba_pkg::S_DONE;
            end

            bba_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = (res_status_reg == bba_pkg::ST_OK) ? idx_reg : '0;
                    out_addr_next   = (res_status_reg == bba_pkg::ST_OK) ? res_addr_reg : '0;
                    state_next      = bba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::S_IDLE;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_ptr_reg   <= word_ptr_next;
        scan_cnt_reg   <= scan_cnt_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        req_addr_reg   <= req_addr_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_addr_reg   <= out_addr_next;
    end

    bba_bitmap u_bitmap
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (bm_ctrl),
        .rd_word (rd_word)
    );

    bba_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (off_reg[bba_pkg::OFF_W-1:0]),
        .divisor   (bs_eff),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_addr_reg, out_index_reg, out_status_reg};

endmodule

/* src/bba_bitmap.sv */
// Bitmap store of used blocks with per-word valid bits for instant clearing.
module bba_bitmap
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  bba_pkg::bm_ctrl_t                 ctrl,
    output logic [bba_pkg::WORD_BITS-1:0]     rd_word
);

    logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::WORDS];
    logic [bba_pkg::WORDS-1:0]     valid_reg;
    logic [bba_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    // A word that was never written since the last clear reads as all free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                valid_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* src/bba_divider.sv */
// Restoring divider that turns a heap offset into a block index, one bit per cycle.
module bba_divider
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [bba_pkg::OFF_W-1:0]       dividend,
    input  logic [bba_pkg::BS_W-1:0]        divisor,
    output logic                            busy,
    output logic [bba_pkg::INDEX_W-1:0]     quotient,
    output logic [bba_pkg::BS_W-1:0]        remainder
);

    logic                            active_reg;
    logic [bba_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [bba_pkg::OFF_W-1:0]       rem_reg;
    logic [bba_pkg::OFF_W-1:0]       den_reg;
    logic [bba_pkg::INDEX_W-1:0]     quot_reg;
    logic                            fits;

    assign fits = (rem_reg >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= bba_pkg::DIV_CNT_W'(bba_pkg::INDEX_W);
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == bba_pkg::DIV_CNT_W'(1))
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // The divisor starts aligned to the top quotient bit and moves down each step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            den_reg  <= bba_pkg::OFF_W'(divisor) << (bba_pkg::INDEX_W - 1);
            quot_reg <= '0;
        end
        else if (active_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            quot_reg <= {quot_reg[bba_pkg::INDEX_W-2:0], fits};
            den_reg  <= den_reg >> 1;
        end
    end

    assign busy      = active_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg[bba_pkg::BS_W-1:0];

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the bitmap block allocator core.
module tb_top;
    import bba_pkg::*;

    // One result beat, split into its fields.
    typedef struct packed {
        status_t     status;
        logic [9:0]  index;
        logic [31:0] address;
    } alloc_result_t;

    // One row of the directed plan: a register setting or a request beat
    // repeated rep times, with the expected result typed in where it is obvious.
    typedef struct packed {
        logic          is_cfg;
        logic [7:0]    rep;
        action_t       act;
        logic [16:0]   size;
        logic [31:0]   addr;
        logic          typed;
        alloc_result_t want;
        logic [5:0]    wc;
        logic [16:0]   bs;
        logic [31:0]   base;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // action [1:0], request_size [18:2], release_address [50:19], zero fill above
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status [1:0], block_index [11:2], block_address [43:12], zero fill above
    logic [47:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #1 clk = ~clk;

    bitmap_block_allocator_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the allocator: the used-block bitmap, the search hint and
    // the raw register values as written (clamping is applied when they are used).
    logic [WORD_BITS-1:0]  shadow_map [WORDS];
    logic [WORD_IDX_W-1:0] shadow_hint;
    logic [5:0]            shadow_words;
    logic [16:0]           shadow_bsize;
    logic [31:0]           shadow_base;

    alloc_result_t pending_results [$];
    int unsigned   granted_blocks [$];
    plan_row_t     directed_plan [$];

    int errors = 0;
    int requests = 0;
    int checked = 0;
    int settings = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int send_idle_pct = 0;
    int stall_pct = 0;

    function automatic void reset_shadow();
        for (int i = 0; i < WORDS; i++)
            shadow_map[i] = '0;
        shadow_hint = '0;
        shadow_words = 6'd32;
        shadow_bsize = 17'd64;
        shadow_base = 32'd0;
    endfunction

    // A word count of zero acts as one word, anything above WORDS as WORDS.
    function automatic int unsigned words_in_use();
        if (shadow_words == 0)
            return 1;
        if (shadow_words > WORDS)
            return WORDS;
        return shadow_words;
    endfunction

    // A block size of zero acts as one byte, anything above 64 KiB as 64 KiB.
    function automatic int unsigned bytes_per_block();
        if (shadow_bsize == 0)
            return 1;
        if (shadow_bsize > MAX_BLOCK)
            return 65536;
        return shadow_bsize;
    endfunction

    function automatic logic [31:0] block_start(int unsigned idx);
        longint unsigned a;
        a = 64'(shadow_base) + 64'(idx) * 64'(bytes_per_block());
        return a[31:0];
    endfunction

    // Applies one request beat to the shadow state and returns its result.
    function automatic alloc_result_t apply_request(action_t act, logic [16:0] size,
                                                    logic [31:0] addr);
        alloc_result_t r;
        int unsigned   wc;
        int unsigned   bs;
        int unsigned   w;
        int unsigned   b;
        int unsigned   idx;
        logic [31:0]   off;
        bit            found;
        wc = words_in_use();
        bs = bytes_per_block();
        r = '{ST_OK, 10'd0, 32'd0};
        found = 1'b0;
        case (act)
            ACT_ALLOC:
            begin
                if (size == 0 || size > bs)
                    r.status = ST_BAD_SIZE;
                else
                begin
                    // Scan from the hint, wrapping inside the words in use;
                    // the first word with room gives its lowest free bit.
                    for (int k = 0; k < wc; k++)
                    begin
                        w = (shadow_hint % wc + k) % wc;
                        if (!found && shadow_map[w] != '1)
                        begin
                            b = 0;
                            for (int i = WORD_BITS - 1; i >= 0; i--)
                                if (!shadow_map[w][i])
                                    b = i;
                            shadow_map[w][b] = 1'b1;
                            shadow_hint = WORD_IDX_W'(w);
                            idx = w * WORD_BITS + b;
                            r = '{ST_OK, 10'(idx), block_start(idx)};
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        r.status = ST_FULL;
                end
            end
            ACT_RELEASE:
            begin
                off = addr - shadow_base;
                if (64'(off) >= 64'(bs) * wc * WORD_BITS)
                    r.status = ST_BAD_ADDR;
                else
                begin
                    idx = off / bs;
                    shadow_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                    r = '{ST_OK, 10'(idx), block_start(idx)};
                end
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < WORDS; i++)
                    shadow_map[i] = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic plan_row_t req(action_t act, logic [16:0] size, logic [31:0] addr,
                                      int rep);
        plan_row_t row;
        row = '0;
        row.rep = 8'(rep);
        row.act = act;
        row.size = size;
        row.addr = addr;
        return row;
    endfunction

    function automatic plan_row_t req_typed(action_t act, logic [16:0] size,
                                            logic [31:0] addr, status_t st,
                                            logic [9:0] idx, logic [31:0] baddr);
        plan_row_t row;
        row = req(act, size, addr, 1);
        row.typed = 1'b1;
        row.want = '{st, idx, baddr};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(logic [5:0] wc, logic [16:0] bs,
                                          logic [31:0] base);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.wc = wc;
        row.bs = bs;
        row.base = base;
        return row;
    endfunction

    // Drives one request beat, with a random idle gap in front of it, and records
    // its expected result once the core takes it. tvalid is lowered only when a
    // gap follows, so back-to-back beats keep it high without a glitch.
    task automatic send_request(action_t act, logic [16:0] size, logic [31:0] addr,
                                bit typed, alloc_result_t want);
        alloc_result_t got;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, addr, size, act};
        do
            @(posedge clk);
        while (!s_tready);
        got = apply_request(act, size, addr);
        pending_results.push_back(typed ? want : got);
        requests++;
        if (act == ACT_ALLOC && got.status == ST_OK)
            granted_blocks.push_back(got.index);
        if (act == ACT_CLEAR)
            granted_blocks.delete();
    endtask

    // Holds the request stream off until every outstanding result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Writes all three registers on an idle core. Bits above each register's
    // width carry random junk, which the core must ignore.
    task automatic set_config(logic [5:0] wc, logic [16:0] bs, logic [31:0] base);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= CFG_WORD_COUNT;
        cfg_data <= {26'($urandom), wc};
        @(posedge clk);
        cfg_index <= CFG_BLOCK_SIZE;
        cfg_data <= {15'($urandom), bs};
        @(posedge clk);
        cfg_index <= CFG_HEAP_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_words = wc;
        shadow_bsize = bs;
        shadow_base = base;
        settings++;
    endtask

    // One random request. Most allocations ask for a legal size, and most
    // releases target a block that was actually handed out, so the bitmap fills,
    // drains and wraps; the rest are bad sizes, stray addresses, clears and no-ops.
    task automatic random_request(output bit counted);
        int unsigned bs;
        int unsigned wc;
        int unsigned pick;
        int unsigned k;
        logic [16:0] size;
        logic [31:0] addr;
        action_t     act;
        bs = bytes_per_block();
        wc = words_in_use();
        pick = $urandom_range(99);
        size = 17'($urandom_range(bs, 1));
        addr = $urandom;
        if (pick < 52)
        begin
            act = ACT_ALLOC;
            if ($urandom_range(9) == 0)
                size = ($urandom_range(1) == 0) ? 17'd0 : 17'($urandom_range(131071));
        end
        else if (pick < 90)
        begin
            act = ACT_RELEASE;
            pick = $urandom_range(9);
            if (pick < 7 && granted_blocks.size() != 0)
            begin
                k = $urandom_range(granted_blocks.size() - 1);
                addr = shadow_base + granted_blocks[k] * bs + $urandom_range(bs - 1);
                granted_blocks.delete(k);
            end
            else if (pick < 9)
                addr = shadow_base + $urandom_range(bs * wc * WORD_BITS - 1);
        end
        else if (pick < 95)
            act = ACT_CLEAR;
        else
            act = ACT_NONE;
        send_request(act, size, addr, 1'b0, '0);
        counted = (act != ACT_NONE);
    endtask

    // Result side: checks each accepted beat against the oldest expectation using
    // values sampled before the edge, then draws the next tready.
    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing outstanding, got %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                status_seen[m_tdata[1:0]]++;
                if (m_tdata[1:0] !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[11:2] !== want.index)
                begin
                    $display("%0t: block_index mismatch, expected %0d, got %0d",
                             $time, want.index, m_tdata[11:2]);
                    errors++;
                end
                if (m_tdata[43:12] !== want.address)
                begin
                    $display("%0t: block_address mismatch, expected %h, got %h",
                             $time, want.address, m_tdata[43:12]);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin : stimulus
        logic [5:0]  wc;
        logic [16:0] bs;
        logic [31:0] base;
        bit          counted;
        int          n;

        // Defaults after reset: 32 words, 64-byte blocks, base 0, 1024 blocks.
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd1, 32'd0, ST_OK, 10'd0, 32'd0));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd64, 32'd0, ST_OK, 10'd1, 32'd64));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd65, 32'd0, ST_BAD_SIZE, 10'd0, 32'd0));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd0, 32'd0, ST_BAD_SIZE, 10'd0, 32'd0));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'h1FFFF, 32'd0,
                                          ST_BAD_SIZE, 10'd0, 32'd0));
        // An address inside a block rounds down to the block start.
        directed_plan.push_back(req_typed(ACT_RELEASE, 17'd0, 32'd127, ST_OK, 10'd1, 32'd64));
        // Releasing a block that is already free still reports ok.
        directed_plan.push_back(req_typed(ACT_RELEASE, 17'd0, 32'd64, ST_OK, 10'd1, 32'd64));
        directed_plan.push_back(req_typed(ACT_RELEASE, 17'd0, 32'hFFFF_FFFF,
                                          ST_BAD_ADDR, 10'd0, 32'd0));
        directed_plan.push_back(req_typed(ACT_RELEASE, 17'd0, 32'd65536,
                                          ST_BAD_ADDR, 10'd0, 32'd0));
        directed_plan.push_back(req_typed(ACT_RELEASE, 17'd0, 32'd65535,
                                          ST_OK, 10'd1023, 32'd65472));
        // The unused action code does nothing, whatever the other fields hold.
        directed_plan.push_back(req_typed(ACT_NONE, 17'h1FFFF, 32'hFFFF_FFFF,
                                          ST_OK, 10'd0, 32'd0));
        directed_plan.push_back(req_typed(ACT_CLEAR, 17'd0, 32'd0, ST_OK, 10'd0, 32'd0));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd1, 32'd0, ST_OK, 10'd0, 32'd0));
        // Word count 0 acts as one word and block size 0 as one byte; the base
        // sits just below the top so block addresses wrap through zero.
        directed_plan.push_back(cfg_row(6'd0, 17'd0, 32'hFFFF_FFF0));
        directed_plan.push_back(req(ACT_ALLOC, 17'd1, 32'd0, 31));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd1, 32'd0, ST_FULL, 10'd0, 32'd0));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd2, 32'd0, ST_BAD_SIZE, 10'd0, 32'd0));
        directed_plan.push_back(req_typed(ACT_RELEASE, 17'd0, 32'd5, ST_OK, 10'd21, 32'd5));
        directed_plan.push_back(req_typed(ACT_RELEASE, 17'd0, 32'hFFFF_FFEF,
                                          ST_BAD_ADDR, 10'd0, 32'd0));
        // Oversized registers clamp to 32 words and 64 KiB blocks; word 0 fills
        // up and the scan moves on to word 1.
        directed_plan.push_back(cfg_row(6'd63, 17'h1FFFF, 32'd0));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd65536, 32'd0,
                                          ST_OK, 10'd21, 32'h0015_0000));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd1, 32'd0, ST_OK, 10'd32, 32'h0020_0000));
        directed_plan.push_back(req_typed(ACT_RELEASE, 17'd0, 32'h03FF_FFFF,
                                          ST_OK, 10'd1023, 32'h03FF_0000));
        // The hint now points past the single word in use, and that word is full.
        directed_plan.push_back(cfg_row(6'd1, 17'd64, 32'd0));
        directed_plan.push_back(req_typed(ACT_ALLOC, 17'd1, 32'd0, ST_FULL, 10'd0, 32'd0));

        reset_shadow();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
                set_config(directed_plan[i].wc, directed_plan[i].bs, directed_plan[i].base);
            else
                repeat (directed_plan[i].rep)
                    send_request(directed_plan[i].act, directed_plan[i].size,
                                 directed_plan[i].addr, directed_plan[i].typed,
                                 directed_plan[i].want);
        end

        // Random phases, each with its own register setting and handshake pacing.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin wc = 6'd1;  bs = 17'd1;      base = 32'd0;          end
                1: begin wc = 6'd2;  bs = 17'd64;     base = 32'hFFFF_FF00;  end
                2: begin wc = 6'd32; bs = 17'd65536;  base = 32'hFFFF_0000;  end
                3: begin wc = 6'd0;  bs = 17'd0;      base = 32'hFFFF_FFFF;  end
                4: begin wc = 6'd63; bs = 17'h1FFFF;  base = $urandom;       end
                6: begin wc = 6'd3;  bs = 17'd16;     base = $urandom;       end
                default:
                begin
                    wc = 6'($urandom_range(63));
                    bs = 17'($urandom_range(512, 1));
                    base = $urandom;
                end
            endcase
            set_config(wc, bs, base);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            n = 0;
            while (n < 100)
            begin
                // Halfway through, let the pipeline run completely dry.
                if (n == 50)
                    wait_drained();
                random_request(counted);
                if (counted)
                    n++;
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Covered %0d request beats under %0d register settings, %0d results checked.",
                 requests, settings, checked);
        $display("Results seen: %0d ok, %0d heap full, %0d bad size, %0d bad address.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD_SIZE],
                 status_seen[ST_BAD_ADDR]);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
